>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ray march column block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define GRMC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define GRMC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

>>> design/grmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_pkg
// Constants, types and helpers shared by the ray march column block.
// ----------------------------------------------------------------------------
package grmc_pkg;

   localparam int MAP_DIM      = 64;
   localparam int MAP_LAYERS   = 4;
   localparam int SCREEN_W     = 1000;
   localparam int SCREEN_H     = 600;
   localparam int MAX_DEPTH_Q8 = 4096;
   localparam int STEP_Q8      = 26;

   localparam int NO_HIT_COLOUR = 4;
   localparam int HALF_CELL_Q8  = 128;

   localparam int MAP_DEPTH = MAP_LAYERS * MAP_DIM * MAP_DIM;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);
   localparam int CIDX_W    = $clog2(MAP_DIM);
   localparam int SIZE_W    = 9;
   localparam int D_W       = 15;
   localparam int TOPQ_W    = 21;

   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // ceil(2^36 / SCREEN_W); exact floor division for products below 2^26
   localparam int         ANG_SHIFT = 36;
   localparam logic [26:0] ANG_RECIP = 27'd68719477;

   localparam logic [2:0] CSR_VIEWER_X     = 3'd0;
   localparam logic [2:0] CSR_VIEWER_Y     = 3'd1;
   localparam logic [2:0] CSR_VIEWER_LAYER = 3'd2;
   localparam logic [2:0] CSR_VIEW_HEADING = 3'd3;
   localparam logic [2:0] CSR_VIEW_SPREAD  = 3'd4;
   localparam logic [2:0] CSR_GRID_WIDTH   = 3'd5;
   localparam logic [2:0] CSR_GRID_HEIGHT  = 3'd6;

   localparam logic ACT_CAST  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [ADDR_W-1:0] map_addr(input logic [1:0] layer,
                                                 input logic [CIDX_W-1:0] y,
                                                 input logic [CIDX_W-1:0] x);
      map_addr = ADDR_W'((int'(layer) * MAP_DIM + int'(y)) * MAP_DIM + int'(x));
   endfunction

endpackage

>>> design/grmc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc channel interfaces
// Valid/ready channels for cast/write requests and column results.
// ----------------------------------------------------------------------------
interface grmc_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [9:0] column;
   logic [5:0] cell_x;
   logic [5:0] cell_y;
   logic [1:0] cell_layer;
   logic [3:0] cell_value;

   modport source (output valid, action, column, cell_x, cell_y, cell_layer,
                   cell_value, input ready);
   modport sink   (input valid, action, column, cell_x, cell_y, cell_layer,
                   cell_value, output ready);
endinterface

interface grmc_rsp_if;
   logic               valid;
   logic               ready;
   logic [9:0]         out_column;
   logic               draw;
   logic signed [15:0] slice_top;
   logic signed [15:0] slice_bottom;
   logic [3:0]         colour_index;
   logic [7:0]         shade_alpha;

   modport source (output valid, out_column, draw, slice_top, slice_bottom,
                   colour_index, shade_alpha, input ready);
   modport sink   (input valid, out_column, draw, slice_top, slice_bottom,
                   colour_index, shade_alpha, output ready);
endinterface

>>> design/grmc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grmc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [grmc_pkg::DIV_NUM_W-1:0] num,
   input  logic [grmc_pkg::DIV_DEN_W-1:0] den,
   output grmc_pkg::div_stat_type         stat,
   output logic [grmc_pkg::DIV_NUM_W-1:0] quo
);
   import grmc_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in, rem_sh;
   logic [DIV_NUM_W-1:0] acc_ff, acc_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff[DIV_DEN_W-1:0], acc_ff[DIV_NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      den_in  = den_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         cnt_in  = '0;
         rem_in  = '0;
         acc_in  = num;
         den_in  = den;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         acc_in = {acc_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = acc_ff;

endmodule

>>> design/grmc_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_map
// Tile map store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module grmc_map (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [grmc_pkg::ADDR_W-1:0] wr_addr,
   input  logic [3:0]                  wr_data,
   input  logic                        rd_en,
   input  logic [grmc_pkg::ADDR_W-1:0] rd_addr,
   output logic [3:0]                  rd_data
);
   import grmc_pkg::*;

   logic [3:0] mem [MAP_DEPTH];
   logic [3:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/grid_ray_march_column.sv
`timescale 1ns / 1ps
// Write beat: taken whenever the sequencer is idle.
// Cast beat: the result follows two divider passes (sine, cosine), then up to 158
//   march steps (multiply, add and map check states each), then a divider pass for
//   the slice height. A ray leaving the map skips the slice-height pass.
// One cast at a time; the next beat is taken once the result is in the output reg.
// Synchronous active-high reset clears control and config; the map is not cleared.
// ----------------------------------------------------------------------------
// grid_ray_march_column
// Layered tile map with a fixed-step ray marcher producing one wall column.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_ray_march_column (
   input  logic        clock,
   input  logic        reset,
   grmc_req_if.sink    req_ch,
   grmc_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import grmc_pkg::*;

   // one-hot sequencer
   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_ANG_WAIT  = 10'b0000000010,
      ST_TRIG_PREP = 10'b0000000100,
      ST_TRIG_GO   = 10'b0000001000,
      ST_TRIG_WAIT = 10'b0000010000,
      ST_STEP_MUL  = 10'b0000100000,
      ST_STEP_ADD  = 10'b0001000000,
      ST_STEP_CHK  = 10'b0010000000,
      ST_TOP_WAIT  = 10'b0100000000,
      ST_RESULT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [13:0] viewer_x_ff, viewer_y_ff;
   logic [1:0]  viewer_layer_ff;
   logic [15:0] view_heading_ff, view_spread_ff;
   logic [6:0]  grid_width_ff, grid_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_x_ff     <= 14'd1280;
         viewer_y_ff     <= 14'd1280;
         viewer_layer_ff <= 2'd0;
         view_heading_ff <= 16'd0;
         view_spread_ff  <= 16'd10923;
         grid_width_ff   <= 7'd64;
         grid_height_ff  <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VIEWER_X:     viewer_x_ff     <= csr_wdata[13:0];
            CSR_VIEWER_Y:     viewer_y_ff     <= csr_wdata[13:0];
            CSR_VIEWER_LAYER: viewer_layer_ff <= csr_wdata[1:0];
            CSR_VIEW_HEADING: view_heading_ff <= csr_wdata;
            CSR_VIEW_SPREAD:  view_spread_ff  <= csr_wdata;
            CSR_GRID_WIDTH:   grid_width_ff   <= csr_wdata[6:0];
            CSR_GRID_HEIGHT:  grid_height_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // grid size clamped to the store
   logic [SIZE_W-1:0] size_w, size_h;
   assign size_w = ({2'b0, grid_width_ff} > SIZE_W'(MAP_DIM)) ? SIZE_W'(MAP_DIM)
                                                              : {2'b0, grid_width_ff};
   assign size_h = ({2'b0, grid_height_ff} > SIZE_W'(MAP_DIM)) ? SIZE_W'(MAP_DIM)
                                                               : {2'b0, grid_height_ff};
   logic layer_ok;
   assign layer_ok = int'(viewer_layer_ff) < MAP_LAYERS;

   // cast datapath registers
   logic [9:0]         column_ff, column_in;
   logic [25:0]        ang_prod_ff, ang_prod_in;
   logic [15:0]        angle_ff, angle_in;
   logic [28:0]        u_ff, u_in;
   logic               trig_neg_ff, trig_neg_in;
   logic               trig_sel_ff, trig_sel_in;
   logic signed [15:0] sin_ff, sin_in, cos_ff, cos_in;
   logic [D_W-1:0]     d_ff, d_in;
   logic signed [31:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic               outside_ff, outside_in;
   logic [3:0]         colour_ff, colour_in;
   logic [TOPQ_W-1:0]  topq_ff, topq_in;

   // output register
   logic               rsp_valid_ff;
   logic [9:0]         rsp_column_ff;
   logic               rsp_draw_ff;
   logic signed [15:0] rsp_top_ff, rsp_bottom_ff;
   logic [3:0]         rsp_colour_ff;
   logic [7:0]         rsp_alpha_ff;
   logic               rsp_load;

   // shared divider
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   div_stat_type         div_stat;
   logic [DIV_NUM_W-1:0] div_quo;

   grmc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   // tile map
   logic              map_we, map_re;
   logic [ADDR_W-1:0] map_waddr, map_raddr;
   logic [3:0]        map_rdata;

   grmc_map u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (req_ch.cell_value),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   logic req_fire;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // write beats land straight in the map; out-of-range cells are dropped
   assign map_we = req_fire && (req_ch.action == ACT_WRITE)
                   && (int'(req_ch.cell_x) < MAP_DIM) && (int'(req_ch.cell_y) < MAP_DIM)
                   && (int'(req_ch.cell_layer) < MAP_LAYERS);
   assign map_waddr = map_addr(req_ch.cell_layer, CIDX_W'(req_ch.cell_y),
                               CIDX_W'(req_ch.cell_x));

   // column * spread, latched at the cast beat; / SCREEN_W by reciprocal
   logic [25:0] ang_prod;
   logic [52:0] ang_scaled;
   logic [15:0] ang_off;
   assign ang_prod   = 26'(req_ch.column) * 26'(view_spread_ff);
   assign ang_scaled = 53'(ang_prod_ff) * 53'(ANG_RECIP);
   assign ang_off    = 16'(ang_scaled >> ANG_SHIFT);

   // sine prep: t*(32768-t) on the folded angle
   logic [15:0] trig_angle;
   logic [14:0] trig_t;
   logic [30:0] trig_u;
   assign trig_angle = angle_ff + (trig_sel_ff ? 16'd16384 : 16'd0);
   assign trig_t     = trig_angle[14:0];
   assign trig_u     = 31'(trig_t) * 31'(16'd32768 - {1'b0, trig_t});

   // march sample: ((pos + half) << 14) + trig*d, cell = >> 22
   logic [D_W-1:0]     d_next;
   logic [14:0]        pos_x_h, pos_y_h;
   logic signed [32:0] base_x, base_y, px, py;
   logic               in_x, in_y;
   logic [CIDX_W-1:0]  cell_cx, cell_cy;

   assign d_next  = d_ff + D_W'(STEP_Q8);
   assign pos_x_h = 15'(viewer_x_ff) + 15'(HALF_CELL_Q8);
   assign pos_y_h = 15'(viewer_y_ff) + 15'(HALF_CELL_Q8);
   assign base_x  = $signed({4'b0, pos_x_h, 14'b0});
   assign base_y  = $signed({4'b0, pos_y_h, 14'b0});
   assign px      = base_x + 33'(prod_x_ff);
   assign py      = base_y + 33'(prod_y_ff);
   assign in_x    = !px[32] && (px[32:22] < 11'(size_w));
   assign in_y    = !py[32] && (py[32:22] < 11'(size_h));
   assign cell_cx = px[22+CIDX_W-1:22];
   assign cell_cy = py[22+CIDX_W-1:22];
   assign map_raddr = map_addr(viewer_layer_ff, cell_cy, cell_cx);

   // fade: 255 * (depth - d) / depth, zero past the depth; depth is 2^12
   logic [D_W-1:0] depth_left;
   logic [22:0]    alpha_num;
   logic [7:0]     alpha_q;
   assign depth_left = (d_ff > D_W'(MAX_DEPTH_Q8)) ? '0 : D_W'(MAX_DEPTH_Q8) - d_ff;
   assign alpha_num  = {depth_left, 8'b0} - 23'(depth_left);
   assign alpha_q    = 8'(alpha_num >> 12);

   logic signed [15:0] trig_mag;
   assign trig_mag = $signed(16'(div_quo));

   always_comb begin
      state_in    = state_ff;
      column_in   = column_ff;
      ang_prod_in = ang_prod_ff;
      angle_in    = angle_ff;
      u_in        = u_ff;
      trig_neg_in = trig_neg_ff;
      trig_sel_in = trig_sel_ff;
      sin_in      = sin_ff;
      cos_in      = cos_ff;
      d_in        = d_ff;
      prod_x_in   = prod_x_ff;
      prod_y_in   = prod_y_ff;
      outside_in  = outside_ff;
      colour_in   = colour_ff;
      topq_in     = topq_ff;
      div_start   = 1'b0;
      div_num     = '0;
      div_den     = '0;
      map_re      = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.action == ACT_CAST)) begin
               column_in   = req_ch.column;
               ang_prod_in = ang_prod;
               state_in    = ST_ANG_WAIT;
            end
         end
         ST_ANG_WAIT: begin
            angle_in    = view_heading_ff - {1'b0, view_spread_ff[15:1]} + ang_off;
            trig_sel_in = 1'b0;
            state_in    = ST_TRIG_PREP;
         end
         ST_TRIG_PREP: begin
            u_in        = u_ff;
            u_in        = 29'(trig_u);
            trig_neg_in = trig_angle[15];
            state_in    = ST_TRIG_GO;
         end
         ST_TRIG_GO: begin
            div_start = 1'b1;
            div_num   = {3'b0, u_ff, 16'b0};
            div_den   = DIV_DEN_W'(32'd1342177280 - {3'b0, u_ff});
            state_in  = ST_TRIG_WAIT;
         end
         ST_TRIG_WAIT: begin
            if (div_stat.done) begin
               if (!trig_sel_ff) begin
                  sin_in      = trig_neg_ff ? -trig_mag : trig_mag;
                  trig_sel_in = 1'b1;
                  state_in    = ST_TRIG_PREP;
               end else begin
                  cos_in     = trig_neg_ff ? -trig_mag : trig_mag;
                  d_in       = '0;
                  outside_in = 1'b0;
                  colour_in  = 4'(NO_HIT_COLOUR);
                  state_in   = ST_STEP_MUL;
               end
            end
         end
         ST_STEP_MUL: begin
            d_in      = d_next;
            prod_x_in = sin_ff * $signed({1'b0, d_next});
            prod_y_in = cos_ff * $signed({1'b0, d_next});
            state_in  = ST_STEP_ADD;
         end
         ST_STEP_ADD: begin
            if (!(in_x && in_y)) begin
               outside_in = 1'b1;
               d_in       = D_W'(MAX_DEPTH_Q8);
               state_in   = ST_RESULT;
            end else begin
               map_re   = layer_ok;
               state_in = ST_STEP_CHK;
            end
         end
         ST_STEP_CHK: begin
            if ((layer_ok && (map_rdata != 4'd0)) || (d_ff > D_W'(MAX_DEPTH_Q8))) begin
               if (layer_ok && (map_rdata != 4'd0)) begin
                  colour_in = map_rdata;
               end
               div_start = 1'b1;
               div_num   = DIV_NUM_W'(SCREEN_H * 256);
               div_den   = DIV_DEN_W'(d_ff);
               state_in  = ST_TOP_WAIT;
            end else begin
               state_in = ST_STEP_MUL;
            end
         end
         ST_TOP_WAIT: begin
            if (div_stat.done) begin
               topq_in  = div_quo[TOPQ_W-1:0];
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // clamp to 16 bits signed
   function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
      if (v > 25'sd32767) begin
         sat16 = 16'sh7FFF;
      end else if (v < -25'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

   logic signed [24:0] top_full, bottom_full;
   assign top_full    = $signed(25'(SCREEN_H / 2)) - $signed(25'(topq_ff));
   assign bottom_full = $signed(25'(SCREEN_H)) - top_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      column_ff   <= column_in;
      ang_prod_ff <= ang_prod_in;
      angle_ff    <= angle_in;
      u_ff        <= u_in;
      trig_neg_ff <= trig_neg_in;
      trig_sel_ff <= trig_sel_in;
      sin_ff      <= sin_in;
      cos_ff      <= cos_in;
      d_ff        <= d_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      outside_ff  <= outside_in;
      colour_ff   <= colour_in;
      topq_ff     <= topq_in;
      if (rsp_load) begin
         rsp_column_ff <= column_ff;
         if (outside_ff) begin
            rsp_draw_ff   <= 1'b0;
            rsp_top_ff    <= '0;
            rsp_bottom_ff <= '0;
            rsp_colour_ff <= '0;
            rsp_alpha_ff  <= '0;
         end else begin
            rsp_draw_ff   <= 1'b1;
            rsp_top_ff    <= sat16(top_full);
            rsp_bottom_ff <= sat16(bottom_full);
            rsp_colour_ff <= colour_ff;
            rsp_alpha_ff  <= alpha_q;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_column   = rsp_column_ff;
   assign rsp_ch.draw         = rsp_draw_ff;
   assign rsp_ch.slice_top    = rsp_top_ff;
   assign rsp_ch.slice_bottom = rsp_bottom_ff;
   assign rsp_ch.colour_index = rsp_colour_ff;
   assign rsp_ch.shade_alpha  = rsp_alpha_ff;

   // a drawn slice always carries a wall colour
   `GRMC_ASSERT_IMPL(a_draw_colour, clock, reset, rsp_valid_ff && rsp_draw_ff,
                     rsp_colour_ff != 4'd0)
   // a ray that left the map reports blank fields
   `GRMC_ASSERT_IMPL(a_blank_outside, clock, reset, rsp_valid_ff && !rsp_draw_ff,
                     (rsp_colour_ff == 4'd0) && (rsp_alpha_ff == 8'd0))
   // the divider is never restarted mid-run
   `GRMC_ASSERT_IMPL(a_div_free, clock, reset, div_start, !div_stat.busy)
   // map data is checked only right after the read was issued
   `GRMC_ASSERT_ALWAYS(a_chk_after_add, clock, reset,
                       (state_ff != ST_STEP_CHK) || ($past(state_ff) == ST_STEP_ADD))

endmodule

>>> tb/sv/grid_ray_march_column_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_march_column_tb
// Fills the tile map, then sends directed and random cast and write beats
// under several viewer settings and idle patterns. Every column result is
// checked field by field against an in-bench ray marcher.
// ----------------------------------------------------------------------------
module grid_ray_march_column_tb;
   import grmc_pkg::*;

   localparam int STALL_LIMIT = 20000;   // cycles with no beat on either side
   localparam int SETTLE      = 16;      // cycles after the last result
   localparam int BOX_DIM     = 12;      // filled cells per axis, layers 0..2
   localparam int OPEN_DIM    = 18;      // filled cells per axis, layer 3

   typedef struct {
      logic [9:0]         column;
      logic               draw;
      logic signed [15:0] top;
      logic signed [15:0] bottom;
      logic [3:0]         colour;
      logic [7:0]         alpha;
   } wall_slice_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   grmc_req_if req_ch ();
   grmc_rsp_if rsp_ch ();

   grid_ray_march_column dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bench copy of the map and the viewer registers
   logic [3:0]  tiles [MAP_DEPTH];
   int unsigned pos_x, pos_y, layer_sel, heading, spread, span_x, span_y;

   wall_slice_type slices_due [$];
   int          mismatches;
   int          snd_idle_pct;
   int          rcv_idle_pct;
   logic        rsp_hold;
   int          quiet_cycles;
   event        hold_ev;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   // parabolic sine, Q1.14, over a 16-bit turn
   function automatic longint sine_q14(input logic [15:0] a);
      longint unsigned t, u;
      longint          s;
      t = a[14:0];
      u = t * (64'd32768 - t);
      s = longint'((u << 16) / ((64'd5 << 28) - u));
      return a[15] ? -s : s;
   endfunction

   // one axis of a march sample; 0 when the sample is off the grid
   function automatic bit on_grid(input int unsigned pos, input longint trig,
                                  input int unsigned d, input int unsigned size,
                                  output int unsigned idx);
      longint p;
      p = (longint'(pos + HALF_CELL_Q8) << 14) + trig * longint'(d);
      idx = 0;
      if (p < 0) return 1'b0;
      if ((p >>> 22) >= size) return 1'b0;
      idx = int'(p >>> 22);
      return 1'b1;
   endfunction

   function automatic longint sat16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic wall_slice_type march_column(input logic [9:0] col);
      wall_slice_type r;
      int unsigned w, h, d, cx, cy, colour;
      logic [15:0] angle;
      longint      sx, cv, top;
      bit          hit, gone;
      w = (span_x > MAP_DIM) ? MAP_DIM : span_x;
      h = (span_y > MAP_DIM) ? MAP_DIM : span_y;
      angle = 16'(heading - (spread >> 1)
                  + int'((longint'(col) * spread) / SCREEN_W));
      sx = sine_q14(angle);
      cv = sine_q14(angle + 16'd16384);
      d = 0;
      colour = NO_HIT_COLOUR;
      hit = 1'b0;
      gone = 1'b0;
      while (!hit && !gone && d <= MAX_DEPTH_Q8) begin
         d += STEP_Q8;
         if (!on_grid(pos_x, sx, d, w, cx) || !on_grid(pos_y, cv, d, h, cy)) begin
            gone = 1'b1;
            d = MAX_DEPTH_Q8;
         end else if (layer_sel < MAP_LAYERS) begin
            if (tiles[(layer_sel * MAP_DIM + cy) * MAP_DIM + cx] != 0) begin
               hit = 1'b1;
               colour = tiles[(layer_sel * MAP_DIM + cy) * MAP_DIM + cx];
            end
         end
      end
      r.column = col;
      if (gone) begin
         r.draw = 1'b0;
         r.top = '0;
         r.bottom = '0;
         r.colour = '0;
         r.alpha = '0;
         return r;
      end
      top = longint'(SCREEN_H / 2) - longint'((SCREEN_H * 256) / d);
      r.draw = 1'b1;
      r.top = 16'(sat16(top));
      r.bottom = 16'(sat16(longint'(SCREEN_H) - top));
      r.colour = 4'(colour);
      r.alpha = (d > MAX_DEPTH_Q8) ? 8'd0 : 8'((255 * (MAX_DEPTH_Q8 - d)) / MAX_DEPTH_Q8);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // result side: ready pattern, long hold-off, checker, watchdog
   // ------------------------------------------------------------------------
   initial begin
      rsp_hold <= 1'b0;
      forever begin
         @(hold_ev);
         rsp_hold <= 1'b1;
         repeat (3000) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (rsp_hold) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      wall_slice_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (slices_due.size() == 0) begin
            $display("%0t: result beat with nothing expected, column %0d",
                     $time, rsp_ch.out_column);
            mismatches++;
         end else begin
            want = slices_due.pop_front();
            if (rsp_ch.out_column !== want.column || rsp_ch.draw !== want.draw ||
                rsp_ch.slice_top !== want.top || rsp_ch.slice_bottom !== want.bottom ||
                rsp_ch.colour_index !== want.colour || rsp_ch.shade_alpha !== want.alpha) begin
               $display("%0t: expected col %0d draw %0d top %0d bot %0d colour %0d alpha %0d",
                        $time, want.column, want.draw, want.top, want.bottom,
                        want.colour, want.alpha);
               $display("%0t: actual   col %0d draw %0d top %0d bot %0d colour %0d alpha %0d",
                        $time, rsp_ch.out_column, rsp_ch.draw, rsp_ch.slice_top,
                        rsp_ch.slice_bottom, rsp_ch.colour_index, rsp_ch.shade_alpha);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // filled square per layer; layer 0 is walled on its border
   function automatic int fill_dim(input int l);
      return (l == MAP_LAYERS - 1) ? OPEN_DIM : BOX_DIM;
   endfunction

   task automatic req_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // one request beat; the model is updated when the beat is taken
   task automatic send_beat(input logic act, input logic [9:0] col,
                            input logic [5:0] x, input logic [5:0] y,
                            input logic [1:0] l, input logic [3:0] v);
      while ($urandom_range(99) < snd_idle_pct) req_idle();
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.column     <= col;
      req_ch.cell_x     <= x;
      req_ch.cell_y     <= y;
      req_ch.cell_layer <= l;
      req_ch.cell_value <= v;
      do @(posedge clock); while (!req_ch.ready);
      if (act == ACT_WRITE) tiles[map_addr(l, y, x)] = v;
      else slices_due.push_back(march_column(col));
   endtask

   task automatic cast(input logic [9:0] col);
      send_beat(ACT_CAST, col, 6'($urandom), 6'($urandom), 2'($urandom), 4'($urandom));
   endtask

   task automatic put_tile(input int l, input int y, input int x, input int v);
      send_beat(ACT_WRITE, 10'($urandom), 6'(x), 6'(y), 2'(l), 4'(v));
   endtask

   // random write that keeps the layer 0 border walled
   task automatic random_tile();
      int l, x, y, v, dim;
      l = $urandom_range(3);
      dim = ($urandom_range(9) == 0) ? MAP_DIM : fill_dim(l);
      x = $urandom_range(dim - 1);
      y = $urandom_range(dim - 1);
      v = ($urandom_range(99) < 30) ? $urandom_range(1, 15) : 0;
      if (l == 0 && (x == 0 || y == 0 || x == BOX_DIM - 1 || y == BOX_DIM - 1))
         v = $urandom_range(1, 15);
      put_tile(l, y, x, v);
   endtask

   // wait for every column, plus a margin for a trailing write
   task automatic drain();
      req_idle();
      while (slices_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write; only called while drained
   task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_VIEWER_X:     pos_x     = val[13:0];
         CSR_VIEWER_Y:     pos_y     = val[13:0];
         CSR_VIEWER_LAYER: layer_sel = val[1:0];
         CSR_VIEW_HEADING: heading   = val;
         CSR_VIEW_SPREAD:  spread    = val;
         CSR_GRID_WIDTH:   span_x    = val[6:0];
         CSR_GRID_HEIGHT:  span_y    = val[6:0];
         default: ;
      endcase
   endtask

   task automatic set_view(input int x, input int y, input int l, input int hd,
                           input int sp, input int w, input int h);
      drain();
      set_reg(CSR_VIEWER_X, 16'(x));
      set_reg(CSR_VIEWER_Y, 16'(y));
      set_reg(CSR_VIEWER_LAYER, 16'(l));
      set_reg(CSR_VIEW_HEADING, 16'(hd));
      set_reg(CSR_VIEW_SPREAD, 16'(sp));
      set_reg(CSR_GRID_WIDTH, 16'(w));
      set_reg(CSR_GRID_HEIGHT, 16'(h));
   endtask

   // rays only ever sample filled cells: either the grid stays inside the
   // filled square, or the viewer sits inside the walled box of layer 0
   task automatic random_view();
      int l, dim;
      l = $urandom_range(3);
      dim = fill_dim(l);
      if (l == 0 && $urandom_range(2) == 0)
         set_view($urandom_range(2815), $urandom_range(2815), 0,
                  $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(127), $urandom_range(127));
      else if ($urandom_range(9) == 0)
         set_view($urandom_range(16383), $urandom_range(16383), l,
                  $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(dim), $urandom_range(dim));
      else
         set_view($urandom_range(dim * 256 - 1), $urandom_range(dim * 256 - 1), l,
                  $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(1, dim), $urandom_range(1, dim));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // every reachable cell gets written: layer 0 walled, 1 dense, 2 sparse, 3 open
   task automatic test_map_fill();
      int pct;
      snd_idle_pct = 0;
      for (int l = 0; l < MAP_LAYERS; l++)
         for (int y = 0; y < fill_dim(l); y++)
            for (int x = 0; x < fill_dim(l); x++) begin
               pct = (l == 0) ? 6 : (l == 1) ? 25 : (l == 2) ? 3 : 0;
               if (l == 0 && (x == 0 || y == 0 || x == BOX_DIM - 1 || y == BOX_DIM - 1))
                  put_tile(l, y, x, $urandom_range(1, 15));
               else
                  put_tile(l, y, x, ($urandom_range(99) < pct) ? $urandom_range(1, 15) : 0);
            end
   endtask

   task automatic test_directed();
      // reset settings: inside the walled box of layer 0
      cast(0); cast(499); cast(999); cast(1000); cast(1023);
      put_tile(0, 1, 1, 15);              // value extremes
      put_tile(0, 1, 2, 0);
      // open layer: depth runs out with no hit
      set_view(128, 128, 3, 0, 0, OPEN_DIM, OPEN_DIM);
      cast(0); cast(1023);
      // spread and heading at the top of range, viewer at the far corner
      set_view(16383, 16383, 0, 65535, 65535, 127, 127);
      cast(0); cast(512); cast(1023);
      // origin corner, one-cell grid, zero-sized grid
      set_view(0, 0, 1, 8192, 16384, 1, 1);
      cast(0); cast(999);
      set_view(4000, 4000, 2, 32768, 10923, 0, 0);
      cast(100); cast(700);
      set_view(0, 16383, 1, 16384, 0, 64, 0);
      cast(3);
      // axis-aligned headings along the walled layer
      for (int q = 0; q < 4; q++) begin
         set_view(1536, 1536, 0, q * 16384, 0, 64, 64);
         cast(0);
      end
   endtask

   // mostly casts with random cells kept fresh by writes
   task automatic test_random(input int snd_pct, input int rcv_pct, input int beats);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      for (int i = 0; i < beats; i++) begin
         if (i % 60 == 0) random_view();
         if ($urandom_range(99) < 30)
            random_tile();
         else
            cast(($urandom_range(9) == 0) ? $urandom_range(1000, 1023) : $urandom_range(999));
      end
   endtask

   // long receiver hold-off while casts keep coming, then a full pause
   task automatic test_backpressure();
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      set_view(1536, 1536, 1, 1000, 20000, BOX_DIM, BOX_DIM);
      -> hold_ev;
      for (int i = 0; i < 12; i++) cast($urandom_range(999));
      drain();
      for (int i = 0; i < 12; i++) cast($urandom_range(999));
   endtask

   initial begin
      mismatches   = 0;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      pos_x = 1280; pos_y = 1280; layer_sel = 0; heading = 0; spread = 10923;
      span_x = 64; span_y = 64;
      reset     <= 1'b1;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACT_CAST;
      req_ch.column     <= '0;
      req_ch.cell_x     <= '0;
      req_ch.cell_y     <= '0;
      req_ch.cell_layer <= '0;
      req_ch.cell_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_map_fill();
      test_directed();
      test_random(10, 88, 200);
      test_random(88, 10, 200);
      test_random(0, 0, 200);
      test_backpressure();
      drain();

      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
